// File: hw/rtl/mcpi_pkg.sv
`timescale 1ns / 1ps

package mcpi_pkg;

  localparam int DEF_PWM_PERIOD_MINUS_ONE = 3999;
  localparam int DEF_GAIN_FRAC_BITS       = 16;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [23:0] RST_PROP_GAIN      = 24'd19661;
  localparam logic [23:0] RST_INT_GAIN       = 24'd1966;
  localparam logic [11:0] RST_INTEGRAL_LIMIT = 12'd3333;
  localparam logic [11:0] RST_TEST_AMPLITUDE = 12'd200;
  localparam logic [6:0]  RST_TEST_LENGTH    = 7'd99;
  localparam logic [6:0]  RST_TEST_FLIP      = 7'd25;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_SET_REF  = 2'd1,
    ACT_SET_MODE = 2'd2,
    ACT_SET_PWM  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_PWM   = 3'd1,
    MODE_TEST  = 3'd2,
    MODE_HOLD  = 3'd3,
    MODE_TRACK = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN      = 3'd0,
    CFG_INT_GAIN       = 3'd1,
    CFG_INTEGRAL_LIMIT = 3'd2,
    CFG_TEST_AMPLITUDE = 3'd3,
    CFG_TEST_LENGTH    = 3'd4,
    CFG_TEST_FLIP      = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [23:0] prop_gain;
    logic [23:0] int_gain;
    logic [11:0] integral_limit;
    logic [11:0] test_amplitude;
    logic [6:0]  test_length;
    logic [6:0]  test_flip_interval;
  } cfg_t;

  // how a word acts on the held duty and direction
  typedef struct packed {
    logic       pi;
    logic       upd_duty;
    logic       upd_rev;
    logic       rev_cmd;
    logic [6:0] pct_mag;
  } drive_ctl_t;

  typedef struct packed {
    mode_t              mode_now;
    logic               command_ok;
    logic               sample_valid;
    logic [6:0]         sample_index;
    logic signed [12:0] sample_measured;
    logic signed [12:0] sample_reference;
  } info_t;

  typedef struct packed {
    logic                  user;
    logic [OUT_DATA_W-1:0] data;
  } out_word_t;

endpackage

// File: hw/rtl/motor_current_pi_controller.sv
`timescale 1ns / 1ps

// Motor current PI regulator. One word per clock is accepted while in_tready
// is high, and one result word is returned for each, in order. The rate is
// set by the control stage, which reads and updates the integral, reference,
// mode and test counters from each word before the next word reaches it; the
// gain multiplies, saturation and duty scaling follow in registered stages
// behind it. in_tready depends only on the fill of a two-word output buffer.
// in_tuser carries the action code; out_tuser is set when a test sample was
// taken. Configuration registers are written through cfg_we/cfg_index/cfg_data
// and must only change while no words are in flight.

module motor_current_pi_controller #(
  parameter int PWM_PERIOD_MINUS_ONE = mcpi_pkg::DEF_PWM_PERIOD_MINUS_ONE,
  parameter int GAIN_FRAC_BITS       = mcpi_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // measured_current, reference_value, new_mode, pwm_percent, zero pad
  input  logic [mcpi_pkg::IN_DATA_W-1:0]  in_tdata,
  // action
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // duty_compare, reverse_drive, mode_now, command_ok, sample_index,
  // sample_measured, sample_reference, zero pad
  output logic [mcpi_pkg::OUT_DATA_W-1:0] out_tdata,
  // sample_valid
  output logic                            out_tuser,
  input  logic                            cfg_we,
  input  logic [mcpi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcpi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mcpi_pkg::*;

  cfg_t       cfg_r;
  logic       en;

  logic               s1_valid;
  logic signed [13:0] s1_err;
  logic signed [12:0] s1_acc;
  drive_ctl_t         s1_drive;
  info_t              s1_info;

  logic                      s4_valid;
  logic [GAIN_FRAC_BITS+6:0] s4_mag;
  logic                      s4_rev;
  logic                      s4_upd_duty;
  logic                      s4_upd_rev;
  info_t                     s4_info;

  logic       push;
  out_word_t  push_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain          <= RST_PROP_GAIN;
      cfg_r.int_gain           <= RST_INT_GAIN;
      cfg_r.integral_limit     <= RST_INTEGRAL_LIMIT;
      cfg_r.test_amplitude     <= RST_TEST_AMPLITUDE;
      cfg_r.test_length        <= RST_TEST_LENGTH;
      cfg_r.test_flip_interval <= RST_TEST_FLIP;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PROP_GAIN:      cfg_r.prop_gain          <= cfg_data;
        CFG_INT_GAIN:       cfg_r.int_gain           <= cfg_data;
        CFG_INTEGRAL_LIMIT: cfg_r.integral_limit     <= cfg_data[11:0];
        CFG_TEST_AMPLITUDE: cfg_r.test_amplitude     <= cfg_data[11:0];
        CFG_TEST_LENGTH:    cfg_r.test_length        <= cfg_data[6:0];
        CFG_TEST_FLIP:      cfg_r.test_flip_interval <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign in_tready = en;

  mcpi_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_action (in_tuser),
    .in_data   (in_tdata),
    .cfg       (cfg_r),
    .s1_valid  (s1_valid),
    .s1_err    (s1_err),
    .s1_acc    (s1_acc),
    .s1_drive  (s1_drive),
    .s1_info   (s1_info)
  );

  mcpi_pi_path #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_pi_path (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .cfg         (cfg_r),
    .s1_valid    (s1_valid),
    .s1_err      (s1_err),
    .s1_acc      (s1_acc),
    .s1_drive    (s1_drive),
    .s1_info     (s1_info),
    .s4_valid    (s4_valid),
    .s4_mag      (s4_mag),
    .s4_rev      (s4_rev),
    .s4_upd_duty (s4_upd_duty),
    .s4_upd_rev  (s4_upd_rev),
    .s4_info     (s4_info)
  );

  mcpi_duty_scale #(
    .PWM_PERIOD_MINUS_ONE (PWM_PERIOD_MINUS_ONE),
    .GAIN_FRAC_BITS       (GAIN_FRAC_BITS)
  ) u_duty_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .s4_valid    (s4_valid),
    .s4_mag      (s4_mag),
    .s4_rev      (s4_rev),
    .s4_upd_duty (s4_upd_duty),
    .s4_upd_rev  (s4_upd_rev),
    .s4_info     (s4_info),
    .push        (push),
    .push_word   (push_word)
  );

  mcpi_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_word  (push_word),
    .room       (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: hw/rtl/mcpi_ctl.sv
`timescale 1ns / 1ps

module mcpi_ctl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [1:0]                 in_action,
  input  logic [mcpi_pkg::IN_DATA_W-1:0] in_data,
  input  mcpi_pkg::cfg_t             cfg,
  output logic                       s1_valid,
  output logic signed [13:0]         s1_err,
  output logic signed [12:0]         s1_acc,
  output mcpi_pkg::drive_ctl_t       s1_drive,
  output mcpi_pkg::info_t            s1_info
);
  import mcpi_pkg::*;

  localparam logic signed [12:0] REF_MIN = {1'b1, 12'b0};
  localparam logic signed [12:0] REF_MAX = {1'b0, {12{1'b1}}};

  // input register
  logic               s0_valid_r;
  action_t            s0_action_r;
  logic signed [12:0] s0_meas_r;
  logic signed [12:0] s0_refv_r;
  logic [2:0]         s0_mode_r;
  logic signed [7:0]  s0_pct_r;

  // loop state
  logic signed [12:0] int_r, int_nxt;
  logic signed [12:0] ref_r, ref_nxt;
  mode_t              mode_r, mode_nxt;
  logic [6:0]         step_r, step_nxt;
  logic [6:0]         phase_r, phase_nxt;

  logic               s1_valid_r;
  logic signed [13:0] s1_err_r;
  logic signed [12:0] s1_acc_r;
  drive_ctl_t         s1_drive_r;
  info_t              s1_info_r;

  logic signed [12:0] ref_t;
  logic [6:0]         phase_t;
  logic [6:0]         phase_inc;
  logic               run;
  logic               pi;
  logic signed [13:0] err;
  logic signed [14:0] acc_sum;
  logic signed [14:0] lim_pos;
  logic signed [14:0] lim_neg;
  logic signed [12:0] acc_clamp;
  logic signed [7:0]  pct_abs;
  drive_ctl_t         drive;
  info_t              info;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_action_r <= action_t'(in_action);
      s0_meas_r   <= in_data[12:0];
      s0_refv_r   <= in_data[25:13];
      s0_mode_r   <= in_data[28:26];
      s0_pct_r    <= in_data[36:29];
    end
  end

  always_comb begin
    int_nxt   = int_r;
    ref_nxt   = ref_r;
    mode_nxt  = mode_r;
    step_nxt  = step_r;
    phase_nxt = phase_r;
    ref_t     = ref_r;
    phase_t   = phase_r;
    phase_inc = '0;
    run       = 1'b0;
    pi        = 1'b0;
    drive     = '0;
    info      = '0;
    info.command_ok = 1'b1;
    pct_abs   = s0_pct_r[7] ? -s0_pct_r : s0_pct_r;

    unique case (s0_action_r)
      ACT_TICK: begin
        unique case (mode_r) inside
          MODE_IDLE: drive.upd_duty = 1'b1;   // magnitude zero, direction kept
          MODE_TEST: begin
            if (step_r == '0) begin
              ref_t   = {1'b0, cfg.test_amplitude};
              phase_t = '0;
              run     = 1'b1;
            end else if (step_r >= cfg.test_length) begin
              mode_nxt = MODE_IDLE;
              step_nxt = '0;
            end else begin
              run = 1'b1;
              if (cfg.test_flip_interval != '0 && phase_r == '0) begin
                ref_t = (ref_r == REF_MIN) ? REF_MAX : -ref_r;
              end
            end
          end
          MODE_HOLD, MODE_TRACK: pi = 1'b1;
          MODE_PWM: ;
          default: ;
        endcase
      end
      ACT_SET_REF: ref_nxt = s0_refv_r;
      ACT_SET_MODE: begin
        if (s0_mode_r <= MODE_TRACK) begin
          mode_nxt = mode_t'(s0_mode_r);
        end else begin
          info.command_ok = 1'b0;
        end
      end
      ACT_SET_PWM: begin
        if (s0_pct_r > 8'sd100 || s0_pct_r < -8'sd100) begin
          info.command_ok = 1'b0;
        end else begin
          drive.upd_duty = 1'b1;
          drive.upd_rev  = 1'b1;
          drive.rev_cmd  = s0_pct_r[7];
          drive.pct_mag  = pct_abs[6:0];
          mode_nxt       = MODE_PWM;
        end
      end
    endcase

    if (run) begin
      pi                    = 1'b1;
      info.sample_valid     = 1'b1;
      info.sample_index     = step_r;
      info.sample_measured  = s0_meas_r;
      info.sample_reference = ref_t;
      ref_nxt               = ref_t;
      step_nxt              = step_r + 7'd1;
      phase_inc             = phase_t + 7'd1;
      phase_nxt             = (phase_inc >= cfg.test_flip_interval) ? 7'd0 : phase_inc;
    end

    err     = {ref_t[12], ref_t} - {s0_meas_r[12], s0_meas_r};
    acc_sum = {{2{int_r[12]}}, int_r} + {err[13], err};
    lim_pos = {3'b000, cfg.integral_limit};
    lim_neg = -lim_pos;
    if (acc_sum > lim_pos) begin
      acc_clamp = lim_pos[12:0];
    end else if (acc_sum < lim_neg) begin
      acc_clamp = lim_neg[12:0];
    end else begin
      acc_clamp = acc_sum[12:0];
    end

    if (pi) begin
      int_nxt        = acc_clamp;
      drive.pi       = 1'b1;
      drive.upd_duty = 1'b1;
      drive.upd_rev  = 1'b1;
    end

    info.mode_now = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_r   <= '0;
      ref_r   <= '0;
      mode_r  <= MODE_IDLE;
      step_r  <= '0;
      phase_r <= '0;
    end else if (en && s0_valid_r) begin
      int_r   <= int_nxt;
      ref_r   <= ref_nxt;
      mode_r  <= mode_nxt;
      step_r  <= step_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_err_r   <= err;
      s1_acc_r   <= acc_clamp;
      s1_drive_r <= drive;
      s1_info_r  <= info;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_err   = s1_err_r;
  assign s1_acc   = s1_acc_r;
  assign s1_drive = s1_drive_r;
  assign s1_info  = s1_info_r;

endmodule

// File: hw/rtl/mcpi_pi_path.sv
`timescale 1ns / 1ps

module mcpi_pi_path #(
  parameter int GAIN_FRAC_BITS = mcpi_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  mcpi_pkg::cfg_t                cfg,
  input  logic                          s1_valid,
  input  logic signed [13:0]            s1_err,
  input  logic signed [12:0]            s1_acc,
  input  mcpi_pkg::drive_ctl_t          s1_drive,
  input  mcpi_pkg::info_t               s1_info,
  output logic                          s4_valid,
  output logic [GAIN_FRAC_BITS+6:0]     s4_mag,
  output logic                          s4_rev,
  output logic                          s4_upd_duty,
  output logic                          s4_upd_rev,
  output mcpi_pkg::info_t               s4_info
);
  import mcpi_pkg::*;

  localparam int MAG_W = GAIN_FRAC_BITS + 7;
  localparam int U_W   = 40;
  localparam logic [U_W-1:0] MAG_FULL = U_W'(100) << GAIN_FRAC_BITS;

  logic signed [38:0] pp_nxt;
  logic signed [37:0] ip_nxt;

  logic               s2_valid_r;
  logic signed [38:0] s2_pp_r;
  logic signed [37:0] s2_ip_r;
  drive_ctl_t         s2_drive_r;
  info_t              s2_info_r;

  logic               s3_valid_r;
  logic signed [U_W-1:0] s3_u_r;
  drive_ctl_t         s3_drive_r;
  info_t              s3_info_r;

  logic               s4_valid_r;
  logic [MAG_W-1:0]   s4_mag_r;
  logic               s4_rev_r;
  logic               s4_upd_duty_r;
  logic               s4_upd_rev_r;
  info_t              s4_info_r;

  logic [U_W-1:0]     u_abs;
  logic [U_W-1:0]     u_sat;
  logic [MAG_W-1:0]   mag_cmd;

  assign pp_nxt = $signed({1'b0, cfg.prop_gain}) * s1_err;
  assign ip_nxt = $signed({1'b0, cfg.int_gain}) * s1_acc;

  // magnitude saturates at 100 % in gain fixed point
  assign u_abs   = s3_u_r[U_W-1] ? -s3_u_r : s3_u_r;
  assign u_sat   = (u_abs > MAG_FULL) ? MAG_FULL : u_abs;
  assign mag_cmd = MAG_W'(s3_drive_r.pct_mag) << GAIN_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pp_r       <= pp_nxt;
      s2_ip_r       <= ip_nxt;
      s2_drive_r    <= s1_drive;
      s2_info_r     <= s1_info;
      s3_u_r        <= {s2_pp_r[38], s2_pp_r} + {{2{s2_ip_r[37]}}, s2_ip_r};
      s3_drive_r    <= s2_drive_r;
      s3_info_r     <= s2_info_r;
      s4_mag_r      <= s3_drive_r.pi ? u_sat[MAG_W-1:0] : mag_cmd;
      s4_rev_r      <= s3_drive_r.pi ? s3_u_r[U_W-1] : s3_drive_r.rev_cmd;
      s4_upd_duty_r <= s3_drive_r.upd_duty;
      s4_upd_rev_r  <= s3_drive_r.upd_rev;
      s4_info_r     <= s3_info_r;
    end
  end

  assign s4_valid    = s4_valid_r;
  assign s4_mag      = s4_mag_r;
  assign s4_rev      = s4_rev_r;
  assign s4_upd_duty = s4_upd_duty_r;
  assign s4_upd_rev  = s4_upd_rev_r;
  assign s4_info     = s4_info_r;

  mag_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    s4_valid_r |-> ({{(U_W-MAG_W){1'b0}}, s4_mag_r} <= MAG_FULL))
    else $error("duty magnitude above full scale");

endmodule

// File: hw/rtl/mcpi_duty_scale.sv
`timescale 1ns / 1ps

module mcpi_duty_scale #(
  parameter int PWM_PERIOD_MINUS_ONE = mcpi_pkg::DEF_PWM_PERIOD_MINUS_ONE,
  parameter int GAIN_FRAC_BITS       = mcpi_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      s4_valid,
  input  logic [GAIN_FRAC_BITS+6:0] s4_mag,
  input  logic                      s4_rev,
  input  logic                      s4_upd_duty,
  input  logic                      s4_upd_rev,
  input  mcpi_pkg::info_t           s4_info,
  output logic                      push,
  output mcpi_pkg::out_word_t       push_word
);
  import mcpi_pkg::*;

  localparam int MAG_W   = GAIN_FRAC_BITS + 7;
  localparam int PERIOD  = PWM_PERIOD_MINUS_ONE + 1;
  localparam int PW      = $clog2(PERIOD + 1);
  // duty = floor(mag * PERIOD / (100 << F)) = floor((mag * PERIOD >> (F + 2)) / 25)
  localparam int X_W       = PW + 5;
  localparam int RECIP_SH  = 32;
  localparam int RECIP_W   = 28;
  localparam longint unsigned RECIP = ((64'd1 << RECIP_SH) + 64'd24) / 64'd25;
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP);
  localparam int Q_W     = X_W + RECIP_W - RECIP_SH;

  logic [MAG_W+PW-1:0]     scaled;
  logic [X_W+RECIP_W-1:0]  qprod;

  logic               s5_valid_r;
  logic [X_W-1:0]     s5_x_r;
  logic               s5_rev_r;
  logic               s5_upd_duty_r;
  logic               s5_upd_rev_r;
  info_t              s5_info_r;

  logic               s6_valid_r;
  logic [Q_W-1:0]     s6_q_r;
  logic               s6_rev_r;
  logic               s6_upd_duty_r;
  logic               s6_upd_rev_r;
  info_t              s6_info_r;

  logic [11:0]        duty_r;
  logic               rev_r;
  logic [Q_W+11:0]    q_ext;
  logic [11:0]        duty_res;
  logic               rev_res;

  assign scaled = s4_mag * PW'(PERIOD);
  assign qprod  = s5_x_r * RECIP_M;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
    end else if (en) begin
      s5_valid_r <= s4_valid;
      s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_x_r        <= scaled[MAG_W+PW-1:GAIN_FRAC_BITS+2];
      s5_rev_r      <= s4_rev;
      s5_upd_duty_r <= s4_upd_duty;
      s5_upd_rev_r  <= s4_upd_rev;
      s5_info_r     <= s4_info;
      s6_q_r        <= qprod[X_W+RECIP_W-1:RECIP_SH];
      s6_rev_r      <= s5_rev_r;
      s6_upd_duty_r <= s5_upd_duty_r;
      s6_upd_rev_r  <= s5_upd_rev_r;
      s6_info_r     <= s5_info_r;
    end
  end

  // held duty and direction live here, so words that leave them alone
  // see every earlier update in order
  assign q_ext    = {12'b0, s6_q_r};
  assign duty_res = s6_upd_duty_r ? q_ext[11:0] : duty_r;
  assign rev_res  = s6_upd_rev_r ? s6_rev_r : rev_r;
  assign push     = en && s6_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r <= '0;
      rev_r  <= 1'b0;
    end else if (push) begin
      duty_r <= duty_res;
      rev_r  <= rev_res;
    end
  end

  always_comb begin
    push_word.user = s6_info_r.sample_valid;
    push_word.data = {6'b0, s6_info_r.sample_reference, s6_info_r.sample_measured,
                      s6_info_r.sample_index, s6_info_r.command_ok,
                      s6_info_r.mode_now, rev_res, duty_res};
  end

  duty_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    s6_valid_r |-> (s6_q_r <= Q_W'(PERIOD)))
    else $error("scaled duty above period");

endmodule

// File: hw/rtl/mcpi_out_buf.sv
`timescale 1ns / 1ps

module mcpi_out_buf (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  mcpi_pkg::out_word_t             push_word,
  output logic                            room,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mcpi_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tuser
);
  import mcpi_pkg::*;

  out_word_t  slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       pop;

  // room looks at the fill count only, so ready never waits on out_tready
  assign room       = (cnt_r != 2'd2);
  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = slot_r[rd_ptr_r].data;
  assign out_tuser  = slot_r[rd_ptr_r].user;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count out of range");

  no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && cnt_r == 2'd2))
    else $error("word pushed into full output buffer");

  ptrs_meet_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("output buffer pointers disagree with count");

endmodule

// File: bench/tb_motor_current_pi_controller.sv
`timescale 1ns / 1ps

module tb_motor_current_pi_controller;
  import mcpi_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PWM_FULL       = DEF_PWM_PERIOD_MINUS_ONE + 1;
  // mode codes the block has to refuse
  localparam logic [2:0] MODE_BAD_LO = 3'd5;
  localparam logic [2:0] MODE_BAD_HI = 3'd7;

  typedef struct {
    logic [11:0]        duty;
    logic               rev;
    logic [2:0]         mode;
    logic               ok;
    logic               sv;
    logic [6:0]         sidx;
    logic signed [12:0] smeas;
    logic signed [12:0] sref;
  } drive_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // measured_current, reference_value, new_mode, pwm_percent, zero pad
  logic [IN_DATA_W-1:0]  in_tdata;
  // action
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // duty_compare, reverse_drive, mode_now, command_ok, sample_index,
  // sample_measured, sample_reference, zero pad
  logic [OUT_DATA_W-1:0] out_tdata;
  // sample_valid
  logic                  out_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  motor_current_pi_controller u_dut (.*);

  // regulator copy: registers
  logic [23:0] kp_gain;
  logic [23:0] ki_gain;
  logic [11:0] integ_limit;
  logic [11:0] test_amp;
  logic [6:0]  test_len;
  logic [6:0]  flip_every;
  // regulator copy: state
  int          integ_sum;
  int          ref_ma;
  mode_t       mode_q;
  int unsigned test_idx;
  int unsigned flip_cnt;
  int unsigned duty_q;
  bit          rev_q;

  drive_result_t pending_drive_q[$];
  drive_result_t seen;
  drive_result_t want;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          words_sent;
  int          results_checked;
  int          samples_seen;
  int          error_count;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void pi_update(int meas);
    longint e;
    longint acc;
    longint lim;
    longint u;
    longint mag;
    longint full;
    e   = longint'(ref_ma) - meas;
    lim = longint'(integ_limit);
    acc = integ_sum + e;
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    integ_sum = int'(acc);
    u     = longint'(kp_gain) * e + longint'(ki_gain) * acc;
    rev_q = (u < 0);
    mag   = (u < 0) ? -u : u;
    full  = longint'(100) << DEF_GAIN_FRAC_BITS;
    if (mag > full) mag = full;
    duty_q = int'((mag * PWM_FULL) / full);
  endfunction

  function automatic void regulator_predict(action_t act, logic signed [12:0] meas,
                                            logic signed [12:0] refv, logic [2:0] nm,
                                            logic signed [7:0] pct);
    drive_result_t r;
    int p;
    r.ok    = 1'b1;
    r.sv    = 1'b0;
    r.sidx  = '0;
    r.smeas = '0;
    r.sref  = '0;
    p = int'(pct);
    case (act)
      ACT_TICK: begin
        if (mode_q == MODE_IDLE) begin
          duty_q = 0;
        end else if (mode_q == MODE_TEST) begin
          if (test_idx != 0 && test_idx >= test_len) begin
            // run over: drop to idle, duty held until the next idle tick
            mode_q   = MODE_IDLE;
            test_idx = 0;
          end else begin
            if (test_idx == 0) begin
              ref_ma   = int'(test_amp);
              flip_cnt = 0;
            end else if (flip_every != 0 && flip_cnt == 0) begin
              ref_ma = (ref_ma == -4096) ? 4095 : -ref_ma;
            end
            r.sv    = 1'b1;
            r.sidx  = test_idx[6:0];
            r.smeas = meas;
            r.sref  = ref_ma[12:0];
            pi_update(meas);
            test_idx = (test_idx + 1) & 'h7f;
            flip_cnt = (flip_cnt + 1) & 'h7f;
            if (flip_cnt >= flip_every) flip_cnt = 0;
          end
        end else if (mode_q == MODE_HOLD || mode_q == MODE_TRACK) begin
          pi_update(meas);
        end
      end
      ACT_SET_REF: ref_ma = int'(refv);
      ACT_SET_MODE: begin
        if (nm <= MODE_TRACK) mode_q = mode_t'(nm);
        else r.ok = 1'b0;
      end
      default: begin
        if (p > 100 || p < -100) begin
          r.ok = 1'b0;
        end else begin
          rev_q  = (p < 0);
          duty_q = ((p < 0) ? -p : p) * PWM_FULL / 100;
          mode_q = MODE_PWM;
        end
      end
    endcase
    r.duty = duty_q[11:0];
    r.rev  = rev_q;
    r.mode = mode_q;
    pending_drive_q.push_back(r);
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_v);
    error_count++;
    if (error_count <= 40)
      $display("[%0t] mismatch on %s at result %0d: got %0d, expected %0d",
               $time, what, results_checked, got, exp_v);
  endtask

  always @(negedge clk) out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      seen.duty  = out_tdata[11:0];
      seen.rev   = out_tdata[12];
      seen.mode  = out_tdata[15:13];
      seen.ok    = out_tdata[16];
      seen.sidx  = out_tdata[23:17];
      seen.smeas = out_tdata[36:24];
      seen.sref  = out_tdata[49:37];
      seen.sv    = out_tuser;
      if (pending_drive_q.size() == 0) begin
        report_mismatch("result word with nothing outstanding", 0, 0);
      end else begin
        want = pending_drive_q.pop_front();
        results_checked++;
        if (want.sv) samples_seen++;
        if (seen.duty !== want.duty) report_mismatch("duty_compare", seen.duty, want.duty);
        if (seen.rev !== want.rev) report_mismatch("reverse_drive", seen.rev, want.rev);
        if (seen.mode !== want.mode) report_mismatch("mode_now", seen.mode, want.mode);
        if (seen.ok !== want.ok) report_mismatch("command_ok", seen.ok, want.ok);
        if (seen.sv !== want.sv) report_mismatch("sample_valid", seen.sv, want.sv);
        if (seen.sidx !== want.sidx) report_mismatch("sample_index", seen.sidx, want.sidx);
        if (seen.smeas !== want.smeas)
          report_mismatch("sample_measured", seen.smeas, want.smeas);
        if (seen.sref !== want.sref)
          report_mismatch("sample_reference", seen.sref, want.sref);
      end
    end
  end

  task automatic send_word(action_t act, logic signed [12:0] meas, logic signed [12:0] refv,
                           logic [2:0] nm, logic signed [7:0] pct);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {3'b000, pct, nm, refv, meas};
    do @(posedge clk); while (in_tready !== 1'b1);
    regulator_predict(act, meas, refv, nm, pct);
    words_sent++;
  endtask

  // unused fields of each word carry noise
  task automatic tick(int meas);
    send_word(ACT_TICK, 13'(meas), 13'($urandom), 3'($urandom), 8'($urandom));
  endtask

  task automatic set_ref(int v);
    send_word(ACT_SET_REF, 13'($urandom), 13'(v), 3'($urandom), 8'($urandom));
  endtask

  task automatic set_mode(logic [2:0] m);
    send_word(ACT_SET_MODE, 13'($urandom), 13'($urandom), m, 8'($urandom));
  endtask

  task automatic set_pwm(int p);
    send_word(ACT_SET_PWM, 13'($urandom), 13'($urandom), 3'($urandom), 8'(p));
  endtask

  // sender stops and waits for every outstanding result
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_drive_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PROP_GAIN:      kp_gain     = val;
      CFG_INT_GAIN:       ki_gain     = val;
      CFG_INTEGRAL_LIMIT: integ_limit = val[11:0];
      CFG_TEST_AMPLITUDE: test_amp    = val[11:0];
      CFG_TEST_LENGTH:    test_len    = val[6:0];
      CFG_TEST_FLIP:      flip_every  = val[6:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic [23:0] kp, logic [23:0] ki, logic [11:0] lim,
                             logic [11:0] amp, logic [6:0] len, logic [6:0] flip);
    settle();
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_INT_GAIN, ki);
    write_reg(CFG_INTEGRAL_LIMIT, 24'(lim));
    write_reg(CFG_TEST_AMPLITUDE, 24'(amp));
    write_reg(CFG_TEST_LENGTH, 24'(len));
    write_reg(CFG_TEST_FLIP, 24'(flip));
  endtask

  // mostly close to the reference so the loop does not just saturate
  function automatic int pick_current();
    int v;
    case ($urandom_range(0, 7))
      0, 1:    return int'($urandom_range(0, 8191)) - 4096;
      2:       v = ref_ma + int'($urandom_range(0, 1200)) - 600;
      default: v = ref_ma + int'($urandom_range(0, 128)) - 64;
    endcase
    if (v > 4095) v = 4095;
    if (v < -4096) v = -4096;
    return v;
  endfunction

  task automatic random_bursts(int n_words);
    int stop;
    int n;
    int p;
    stop = words_sent + n_words;
    while (words_sent < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          set_mode($urandom_range(0, 1) ? MODE_HOLD : MODE_TRACK);
          if ($urandom_range(0, 1)) set_ref(int'($urandom_range(0, 8191)) - 4096);
          n = $urandom_range(1, 30);
          repeat (n) tick(pick_current());
        end
        3, 4, 5: begin
          set_mode(MODE_TEST);
          n = $urandom_range(1, test_len + 3);
          repeat (n) begin
            tick(pick_current());
            // leave the run part way and come back to it
            if ($urandom_range(0, 24) == 0) begin
              set_mode(3'($urandom_range(0, 4)));
              if ($urandom_range(0, 1)) set_ref(int'($urandom_range(0, 8191)) - 4096);
              set_mode(MODE_TEST);
            end
          end
        end
        6, 7: begin
          if ($urandom_range(0, 3) == 0) p = int'($urandom_range(0, 255)) - 128;
          else p = int'($urandom_range(0, 200)) - 100;
          set_pwm(p);
          if ($urandom_range(0, 3) == 0) set_mode($urandom_range(0, 1) ? MODE_PWM : MODE_IDLE);
          n = $urandom_range(0, 4);
          repeat (n) tick(pick_current());
        end
        default: begin
          n = $urandom_range(1, 6);
          repeat (n)
            send_word(action_t'($urandom_range(0, 3)), 13'($urandom), 13'($urandom),
                      3'($urandom), 8'($urandom));
        end
      endcase
    end
  endtask

  task automatic test_reset_idle();
    tick(4095);
  endtask

  task automatic test_commands();
    set_pwm(-128);
    set_pwm(127);
    set_pwm(-100);
    tick(-4096);
    set_pwm(100);
    set_mode(MODE_BAD_LO);
    set_mode(MODE_BAD_HI);
  endtask

  task automatic test_pi_extremes();
    set_mode(MODE_HOLD);
    set_ref(4095);
    tick(-4096);
    set_ref(-4096);
    tick(4095);
    set_mode(MODE_TRACK);
    tick(0);
  endtask

  // three-tick run flipping every tick, interrupted after two samples;
  // the resumed run negates a -4096 reference
  task automatic test_square_wave();
    settle();
    write_reg(CFG_TEST_AMPLITUDE, 24'd4095);
    write_reg(CFG_TEST_LENGTH, 24'd3);
    write_reg(CFG_TEST_FLIP, 24'd1);
    set_mode(MODE_TEST);
    tick(100);
    tick(-100);
    set_mode(MODE_IDLE);
    set_ref(-4096);
    set_mode(MODE_TEST);
    tick(0);
    tick(0);
    tick(0);
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      send_idle_pct = (ph < 2) ? 16 : (ph < 4) ? 81 : 0;
      recv_idle_pct = (ph < 2) ? 81 : (ph < 4) ? 16 : 0;
      case (ph)
        0: load_config(24'hFFFFFF, 24'hFFFFFF, 12'd4095, 12'd4095, 7'd127, 7'd127);
        1: load_config(24'd0, 24'd0, 12'd0, 12'd0, 7'd1, 7'd1);
        2: load_config(RST_PROP_GAIN, RST_INT_GAIN, RST_INTEGRAL_LIMIT, RST_TEST_AMPLITUDE,
                       RST_TEST_LENGTH, RST_TEST_FLIP);
        default: load_config(24'($urandom_range(0, 1 << 18)), 24'($urandom_range(0, 1 << 14)),
                             12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                             7'($urandom_range(1, 40)), 7'($urandom_range(1, 20)));
      endcase
      random_bursts(265);
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = ACT_TICK;
    cfg_we      = 1'b0;
    cfg_index   = CFG_PROP_GAIN;
    cfg_data    = '0;
    kp_gain     = RST_PROP_GAIN;
    ki_gain     = RST_INT_GAIN;
    integ_limit = RST_INTEGRAL_LIMIT;
    test_amp    = RST_TEST_AMPLITUDE;
    test_len    = RST_TEST_LENGTH;
    flip_every  = RST_TEST_FLIP;
    integ_sum   = 0;
    ref_ma      = 0;
    mode_q      = MODE_IDLE;
    test_idx    = 0;
    flip_cnt    = 0;
    duty_q      = 0;
    rev_q       = 1'b0;
    send_idle_pct   = 16;
    recv_idle_pct   = 81;
    words_sent      = 0;
    results_checked = 0;
    samples_seen    = 0;
    error_count     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_idle();
    test_commands();
    test_pi_extremes();
    test_square_wave();
    test_random_traffic();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words: commands, PI ticks and square-wave runs over six register",
             words_sent);
    $display("settings and three stall patterns; %0d results checked, %0d test samples.",
             results_checked, samples_seen);
    if (error_count == 0) begin
      $display("tb_motor_current_pi_controller: clean");
    end else begin
      $display("tb_motor_current_pi_controller: errors");
    end
    $finish;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[%0t] watchdog: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb_motor_current_pi_controller: errors");
    $finish;
  end

endmodule
